FILE: rtl/rsi_pkg.sv
// Shared widths, side-band structs and saturation helper for the ray/sphere intersector.
package rsi_pkg;

  localparam int QW = 72;          // quarter discriminant, Q32.32 with headroom
  localparam int SW = QW / 2;      // square root bits
  localparam int RW = SW + 3;      // square root partial remainder
  localparam int BW = 36;          // half linear coefficient, signed Q16.16
  localparam int TW = 38;          // root candidates, signed
  localparam int NQ = 32;          // quotient bits of the normal divider

  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN  = 32'h8000_0000;

  typedef struct packed {
    logic                 ok;
    logic signed [BW-1:0] b;
    logic [2:0][31:0]     o;
    logic [2:0][31:0]     u;
  } sq_side_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      dlen;
    logic [2:0][31:0] h;
  } dv_side_t;

  typedef struct packed {
    logic [2:0]         neg;
    logic [2:0]         ovf;
    logic [2:0][NQ-1:0] q;
  } dv_res_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = POS_MAX;
    end else if (v < -34'sd2147483648) begin
      r = NEG_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/rsi_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
module rsi_isqrt
  import rsi_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [QW-1:0] rad_i,
  input  sq_side_t      side_i,
  output logic          valid_o,
  output logic [SW-1:0] root_o,
  output sq_side_t      side_o
);

  logic          v_q    [SW];
  logic [RW-1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [QW-1:0] rad_q  [SW];
  sq_side_t      side_q [SW];

  logic [RW-1:0] rem_d  [SW];
  logic [SW-1:0] root_d [SW];
  logic [QW-1:0] rad_d  [SW];
  logic          v_d    [SW];
  sq_side_t      side_d [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [RW-1:0] prem, cur, trial;
    logic [SW-1:0] proot;
    logic [QW-1:0] prad;
    logic          ge;
    if (k == 0) begin : g_first
      assign prem      = '0;
      assign proot     = '0;
      assign prad      = rad_i;
      assign v_d[k]    = valid_i;
      assign side_d[k] = side_i;
    end else begin : g_next
      assign prem      = rem_q[k-1];
      assign proot     = root_q[k-1];
      assign prad      = rad_q[k-1];
      assign v_d[k]    = v_q[k-1];
      assign side_d[k] = side_q[k-1];
    end
    // bring down the next two radicand bits and try root*4+1
    assign cur       = {prem[RW-3:0], prad[QW-1:QW-2]};
    assign trial     = {{(RW-SW-2){1'b0}}, proot, 2'b01};
    assign ge        = (cur >= trial);
    assign rem_d[k]  = ge ? (cur - trial) : cur;
    assign root_d[k] = {proot[SW-2:0], ge};
    assign rad_d[k]  = {prad[QW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SW; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < SW; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SW; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = v_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign side_o  = side_q[SW-1];

endmodule

FILE: rtl/rsi_ndiv.sv
// Pipelined restoring divider for the three normal components, with overflow detect.
module rsi_ndiv
  import rsi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [30:0]      r_i,
  input  logic [2:0][32:0] mag_i,
  input  logic [2:0]       neg_i,
  input  dv_side_t         side_i,
  output logic             valid_o,
  output dv_res_t          res_o,
  output dv_side_t         side_o
);

  localparam int NS = NQ + 1;

  logic               v_q    [NS];
  logic [2:0][30:0]   rem_q  [NS];
  logic [2:0][1:0]    nb_q   [NS];
  logic [2:0][NQ-1:0] q_q    [NS];
  logic [2:0]         ovf_q  [NS];
  logic [2:0]         neg_q  [NS];
  dv_side_t           side_q [NS];

  logic               v_d    [NS];
  logic [2:0][30:0]   rem_d  [NS];
  logic [2:0][1:0]    nb_d   [NS];
  logic [2:0][NQ-1:0] q_d    [NS];
  logic [2:0]         ovf_d  [NS];
  logic [2:0]         neg_d  [NS];
  dv_side_t           side_d [NS];

  // numerator is mag * 2^30; its top bits seed the remainder, two low bits follow
  always_comb begin
    v_d[0]    = valid_i;
    neg_d[0]  = neg_i;
    side_d[0] = side_i;
    for (int i = 0; i < 3; i++) begin
      rem_d[0][i] = mag_i[i][32:2];
      ovf_d[0][i] = (mag_i[i][32:2] >= r_i);
      nb_d[0][i]  = mag_i[i][1:0];
      q_d[0][i]   = '0;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    always_comb begin
      logic [31:0] cur;
      logic [31:0] dif;
      v_d[k]    = v_q[k-1];
      neg_d[k]  = neg_q[k-1];
      ovf_d[k]  = ovf_q[k-1];
      side_d[k] = side_q[k-1];
      for (int i = 0; i < 3; i++) begin
        cur = {rem_q[k-1][i], nb_q[k-1][i][1]};
        dif = cur - {1'b0, r_i};
        if (cur >= {1'b0, r_i}) begin
          rem_d[k][i] = dif[30:0];
          q_d[k][i]   = {q_q[k-1][i][NQ-2:0], 1'b1};
        end else begin
          rem_d[k][i] = cur[30:0];
          q_d[k][i]   = {q_q[k-1][i][NQ-2:0], 1'b0};
        end
        nb_d[k][i] = {nb_q[k-1][i][0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < NS; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k]  <= rem_d[k];
        nb_q[k]   <= nb_d[k];
        q_q[k]    <= q_d[k];
        ovf_q[k]  <= ovf_d[k];
        neg_q[k]  <= neg_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o   = v_q[NS-1];
  assign res_o.neg = neg_q[NS-1];
  assign res_o.ovf = ovf_q[NS-1];
  assign res_o.q   = q_q[NS-1];
  assign side_o    = side_q[NS-1];

endmodule

FILE: rtl/ray_sphere_intersect.sv
// Top level of the fixed-point ray/sphere intersector.
//
// Usage:
//   Sphere centre (indices 0..2, signed Q16.16) and radius (index 3, Q16.16)
//   are written on the cfg channel while no ray is in flight; cfg_ready_o
//   is always high. Each word on s_axis is one ray: origin in Q16.16 and a
//   unit direction in Q2.30. Each word on m_axis is one result: hit flag in
//   tuser; distance, hit point and unit normal in tdata, all zero on a miss.
//   The pipeline forms the quadratic, takes the square root (one root bit
//   per stage), chooses the root and the hit point, divides for the normal
//   (one quotient bit per stage) and ends in the output register.
//   Throughput is one ray per cycle while the output buffer has room;
//   every stage advances together.
//   A two-word output buffer sits after the pipeline: while one result
//   waits on a stalled receiver, the pipeline still moves until a second
//   result fills the buffer, then holds with s_axis_tready low until the
//   receiver takes a word. Nothing is dropped or repeated.
//   Reset clears all valid bits, sets the centre to the origin and the
//   radius to 1.0.
module ray_sphere_intersect
  import rsi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, zero pad
  output logic [223:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    REG_CX  = 2'd0,
    REG_CY  = 2'd1,
    REG_CZ  = 2'd2,
    REG_RAD = 2'd3
  } reg_e;

  logic [2:0][31:0] cen_q;
  logic [30:0]      rad_q;
  logic             en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q <= '0;
      rad_q <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_CX:  cen_q[0] <= cfg_data_i;
        REG_CY:  cen_q[1] <= cfg_data_i;
        REG_CZ:  cen_q[2] <= cfg_data_i;
        REG_RAD: rad_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- quadratic set-up ----------------
  logic                    v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [2:0][31:0]        o1_q, o2_q, o3_q, o4_q, o5_q, o6_q;
  logic [2:0][31:0]        u1_q, u2_q, u3_q, u4_q, u5_q, u6_q;
  logic signed [32:0]      d1_q [3];
  logic signed [64:0]      p2_q [3];
  logic [65:0]             dsq2_q [3];
  logic [61:0]             rr2_q, rr3_q, rr4_q, rr5_q;
  logic                    rz2_q, rz3_q, rz4_q, rz5_q;
  logic signed [BW-1:0]    b3_q, b4_q, b5_q, b6_q;
  logic [67:0]             dd3_q, dd4_q, dd5_q;
  logic [63:0]             pll4_q;
  logic [34:0]             plh4_q;
  logic [5:0]              phh4_q;
  logic [69:0]             bsq5_q;
  logic                    ok6_q;
  logic [QW-1:0]           qd6_q;

  logic signed [66:0]      psum;
  logic [34:0]             bmag;
  logic [70:0]             top;

  always_comb begin
    psum = 67'(p2_q[0]) + 67'(p2_q[1]) + 67'(p2_q[2]);
    bmag = 35'(b3_q[BW-1] ? -b3_q : b3_q);
    top  = 71'(bsq5_q) + 71'(rr5_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o1_q[i] <= s_axis_tdata[32*i +: 32];
        u1_q[i] <= s_axis_tdata[96 + 32*i +: 32];
        d1_q[i] <= 33'($signed(s_axis_tdata[32*i +: 32])) - 33'($signed(cen_q[i]));
        p2_q[i]   <= 65'($signed(u1_q[i])) * 65'(d1_q[i]);
        dsq2_q[i] <= 66'(66'(d1_q[i]) * 66'(d1_q[i]));
      end
      rr2_q  <= 62'(rad_q) * 62'(rad_q);
      rz2_q  <= (rad_q == '0);
      o2_q   <= o1_q;  u2_q <= u1_q;
      // stage 3: floor((U.D) / 2^30) and D.D
      b3_q   <= BW'(psum >>> 30);
      dd3_q  <= 68'(dsq2_q[0]) + 68'(dsq2_q[1]) + 68'(dsq2_q[2]);
      rr3_q  <= rr2_q; rz3_q <= rz2_q;
      o3_q   <= o2_q;  u3_q <= u2_q;
      // stage 4: partial products of B*B
      pll4_q <= 64'(bmag[31:0]) * 64'(bmag[31:0]);
      plh4_q <= 35'(bmag[31:0]) * 35'(bmag[34:32]);
      phh4_q <= 6'(bmag[34:32]) * 6'(bmag[34:32]);
      b4_q   <= b3_q;  dd4_q <= dd3_q; rr4_q <= rr3_q; rz4_q <= rz3_q;
      o4_q   <= o3_q;  u4_q <= u3_q;
      // stage 5: B*B
      bsq5_q <= 70'(pll4_q) + (70'(plh4_q) << 33) + (70'(phh4_q) << 64);
      b5_q   <= b4_q;  dd5_q <= dd4_q; rr5_q <= rr4_q; rz5_q <= rz4_q;
      o5_q   <= o4_q;  u5_q <= u4_q;
      // stage 6: discriminant test
      ok6_q  <= !rz5_q && (71'(dd5_q) <= top);
      qd6_q  <= QW'(top - 71'(dd5_q));
      b6_q   <= b5_q;
      o6_q   <= o5_q;  u6_q <= u5_q;
    end
  end

  // ---------------- square root ----------------
  sq_side_t      sq_in, sq_out;
  logic          sq_valid;
  logic [SW-1:0] sq_root;

  assign sq_in = '{ok: ok6_q, b: b6_q, o: o6_q, u: u6_q};

  rsi_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rad_i   (ok6_q ? qd6_q : '0),
    .side_i  (sq_in),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_out)
  );

  // ---------------- root choice and hit point ----------------
  logic signed [TW-1:0] tn, tf, tsel;
  logic                 v7_q, v8_q, v9_q;
  logic                 hit7_q, hit8_q, hit9_q;
  logic [30:0]          dist7_q, dist8_q, dist9_q;
  logic [2:0][31:0]     o7_q, o8_q, u7_q;
  logic signed [63:0]   m8_q [3];
  logic [2:0][31:0]     h9_q;
  logic [2:0][32:0]     mag9_q;
  logic [2:0]           neg9_q;
  logic [2:0][31:0]     hcur;
  logic signed [32:0]   dif [3];

  always_comb begin
    tn   = -TW'(sq_out.b) - TW'({1'b0, sq_root});
    tf   = -TW'(sq_out.b) + TW'({1'b0, sq_root});
    tsel = (tn > 0) ? tn : tf;
    for (int i = 0; i < 3; i++) begin
      hcur[i] = sat32(34'($signed(o8_q[i])) + 34'(m8_q[i] >>> 30));
      dif[i]  = 33'($signed(hcur[i])) - 33'($signed(cen_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v7_q, v8_q, v9_q} <= '0;
    end else if (en) begin
      v7_q <= sq_valid;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit7_q  <= sq_out.ok && (tsel > 0);
      dist7_q <= (tsel > TW'(DIST_MAX)) ? DIST_MAX : tsel[30:0];
      o7_q    <= sq_out.o;
      u7_q    <= sq_out.u;
      for (int i = 0; i < 3; i++) begin
        m8_q[i] <= 64'($signed(u7_q[i])) * 64'($signed({1'b0, dist7_q}));
      end
      hit8_q  <= hit7_q; dist8_q <= dist7_q; o8_q <= o7_q;
      for (int i = 0; i < 3; i++) begin
        h9_q[i]   <= hcur[i];
        neg9_q[i] <= dif[i][32];
        mag9_q[i] <= dif[i][32] ? 33'(-dif[i]) : 33'(dif[i]);
      end
      hit9_q  <= hit8_q; dist9_q <= dist8_q;
    end
  end

  // ---------------- normal division ----------------
  dv_side_t dv_in, dv_out;
  dv_res_t  dv_res;
  logic     dv_valid;

  assign dv_in = '{hit: hit9_q, dlen: dist9_q, h: h9_q};

  rsi_ndiv u_ndiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v9_q),
    .r_i     (rad_q),
    .mag_i   (mag9_q),
    .neg_i   (neg9_q),
    .side_i  (dv_in),
    .valid_o (dv_valid),
    .res_o   (dv_res),
    .side_o  (dv_out)
  );

  // ---------------- result and output buffer ----------------
  logic [2:0][31:0] nrm;
  logic [223:0]     res_data;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_res.neg[i]) begin
        nrm[i] = (dv_res.ovf[i] || dv_res.q[i] > NEG_MIN) ? NEG_MIN : -dv_res.q[i];
      end else begin
        nrm[i] = (dv_res.ovf[i] || dv_res.q[i][NQ-1]) ? POS_MAX : dv_res.q[i];
      end
    end
    if (dv_out.hit) begin
      res_data = {1'b0, nrm[2], nrm[1], nrm[0], dv_out.h[2], dv_out.h[1], dv_out.h[0],
                  dv_out.dlen};
    end else begin
      res_data = '0;
    end
  end

  logic         ov_q, sv_q;
  logic [223:0] od_q, sd_q;
  logic         oh_q, sh_q;
  logic         push, pop;

  assign en   = !(ov_q && sv_q);
  assign push = en && dv_valid;
  assign pop  = ov_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || pop) begin
      ov_q <= sv_q || push;
      sv_q <= sv_q && push;
    end else if (push) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || pop) begin
      if (sv_q) begin
        od_q <= sd_q;
        oh_q <= sh_q;
        if (push) begin
          sd_q <= res_data;
          sh_q <= dv_out.hit;
        end
      end else if (push) begin
        od_q <= res_data;
        oh_q <= dv_out.hit;
      end
    end else if (push) begin
      sd_q <= res_data;
      sh_q <= dv_out.hit;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = oh_q;

`ifndef SYNTHESIS
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q) else $error("skid word held without an output word");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss word carries non-zero data");

  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[30:0] != '0))
    else $error("hit word with zero distance");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the fixed-point ray/sphere intersector.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 79;
  localparam int WD_LIMIT = 4000;

  localparam logic [1:0] REG_CX = 2'd0;
  localparam logic [1:0] REG_CY = 2'd1;
  localparam logic [1:0] REG_CZ = 2'd2;
  localparam logic [1:0] REG_RAD = 2'd3;

  typedef struct packed {
    logic        hit;
    logic [30:0] dlen;
    logic [2:0][31:0] h;
    logic [2:0][31:0] n;
  } hit_rec_t;

  // sphere geometry and exact intersection arithmetic
  class hit_scoreboard;
    logic signed [31:0] cen[3];
    logic [30:0] rad;
    hit_rec_t pending[$];
    int errors;

    function new();
      cen[0] = 0; cen[1] = 0; cen[2] = 0;
      rad = 31'd65536;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == REG_RAD) rad = val[30:0];
      else cen[idx] = val;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -128'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
    endfunction

    function void note_ray(logic [191:0] w);
      logic signed [127:0] o[3], u[3], d[3], acc, bq, dd, top, s, t, h, nr;
      hit_rec_t e;
      e = '0;
      acc = 0; dd = 0;
      for (int i = 0; i < 3; i++) begin
        o[i] = $signed(w[32*i +: 32]);
        u[i] = $signed(w[96 + 32*i +: 32]);
        d[i] = o[i] - cen[i];
        acc += u[i] * d[i];
        dd += d[i] * d[i];
      end
      bq = acc >>> 30;
      top = bq * bq + $signed({97'd0, rad}) * $signed({97'd0, rad});
      if (rad != 0 && dd <= top) begin
        s = $signed({64'd0, isqrt(top - dd)});
        t = -bq - s;
        if (t <= 0) t = -bq + s;
        if (t > 0) begin
          if (t > 128'sd2147483647) t = 128'sd2147483647;
          e.hit = 1'b1;
          e.dlen = t[30:0];
          for (int i = 0; i < 3; i++) begin
            h = clamp32(o[i] + ((u[i] * t) >>> 30));
            nr = ((h - cen[i]) * 128'sd1073741824) / $signed({97'd0, rad});
            e.h[i] = h[31:0];
            e.n[i] = clamp32(nr);
          end
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic usr, logic [223:0] w);
      hit_rec_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (usr !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, usr); errors++;
      end
      if (w[30:0] !== e.dlen) begin
        $error("distance exp %0h got %0h", e.dlen, w[30:0]); errors++;
      end
      for (int i = 0; i < 3; i++) begin
        if (w[31 + 32*i +: 32] !== e.h[i]) begin
          $error("hit_%0d exp %0h got %0h", i, e.h[i], w[31 + 32*i +: 32]); errors++;
        end
        if (w[127 + 32*i +: 32] !== e.n[i]) begin
          $error("normal_%0d exp %0h got %0h", i, e.n[i], w[127 + 32*i +: 32]); errors++;
        end
      end
      if (w[223:223] !== 1'b0) begin
        $error("pad exp 0 got %0h", w[223]); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [1:0] cfg_addr_i = '0;
  logic [31:0] cfg_data_i = '0;

  hit_scoreboard sb = new();
  int idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ray_sphere_intersect dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_ray(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WD_LIMIT) begin
      $display("** ray_sphere_intersect: FAILED **");
      $finish;
    end
  end

  // receiver may stall after each word, with a random wait; first stretch and words past 600 stall-free
  int recv_words = 0;
  int rx_wait = 0;
  always @(posedge clk_i) begin
    int w;
    if (m_axis_tvalid && m_axis_tready) begin
      recv_words <= recv_words + 1;
      w = (recv_words < 40 || recv_words > 600) ? 0 : int'($urandom_range(0, 5));
      rx_wait <= w;
      m_axis_tready <= (w == 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] r);
    write_reg(REG_CX, cx);
    write_reg(REG_CY, cy);
    write_reg(REG_CZ, cz);
    write_reg(REG_RAD, r);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                          bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 5) : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {uz, uy, ux, oz, oy, ox};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic stop_rays();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord(int range_sel);
    case (range_sel)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // near-unit direction by picking a dominant axis; one draw in 16 is fully random
  task automatic rnd_dir(output logic [31:0] d[3]);
    int ax;
    ax = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++)
      d[i] = $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
    d[ax] = $urandom_range(0, 1) ? 32'h3800_0000 : 32'hC800_0000;
    if ($urandom_range(0, 15) == 0)
      for (int i = 0; i < 3; i++) d[i] = $urandom();
  endtask

  task automatic random_phase(int n, int sel);
    logic [31:0] d[3];
    logic [31:0] o[3];
    for (int k = 0; k < n; k++) begin
      rnd_dir(d);
      for (int i = 0; i < 3; i++) begin
        // aim the origin back along the direction so many rays hit
        o[i] = $signed(sb.cen[i]) + rnd_coord(sel);
        if ($urandom_range(0, 1)) o[i] = $signed(o[i]) - ($signed(d[i]) >>> 10);
      end
      send_ray(o[0], o[1], o[2], d[0], d[1], d[2], k % 50 >= 10);
    end
    stop_rays();
  endtask

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] MONE_Q30 = 32'hC000_0000;

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset sphere, unit radius
    send_ray(32'hFFFB_0000, 0, 0, ONE_Q30, 0, 0, 1'b0);         // two roots in front
    send_ray(0, 0, 0, 0, ONE_Q30, 0, 1'b0);                      // origin inside
    send_ray(32'h0005_0000, 0, 0, ONE_Q30, 0, 0, 1'b0);          // sphere behind
    send_ray(32'hFFFB_0000, 32'h0001_0000, 0, ONE_Q30, 0, 0, 1'b0); // tangent
    send_ray(32'hFFFB_0000, 32'h0002_0000, 0, ONE_Q30, 0, 0, 1'b0); // clear miss
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_ray(0, 0, 32'hFFFF_0000, 0, 0, 0, 1'b0);                // zero direction
    send_ray(0, 0, 0, 0, 0, MONE_Q30, 1'b0);
    stop_rays();
    drain();

    // zero radius: always a miss
    set_sphere(0, 0, 0, 0);
    send_ray(32'hFFFB_0000, 0, 0, ONE_Q30, 0, 0, 1'b0);
    send_ray(0, 0, 0, 0, ONE_Q30, 0, 1'b0);
    stop_rays();
    drain();

    // huge sphere far away: distance saturation
    set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, ONE_Q30, MONE_Q30, ONE_Q30, 1'b0);
    send_ray(0, 0, 0, ONE_Q30, 0, 0, 1'b0);
    send_ray(32'h8000_0000, 0, 0, MONE_Q30, 0, 0, 1'b0);
    stop_rays();
    drain();

    set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    send_ray(32'h8000_0000, 32'h7FFF_0000, 32'h8000_0000, 0, ONE_Q30, 0, 1'b0);
    stop_rays();
    drain();

    set_sphere(32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000, 32'h0002_0000);
    random_phase(200, 1);
    drain();   // sender holds until every result is back

    set_sphere($urandom(), $urandom(), $urandom(), $urandom_range(1, 32'h00FF_FFFF));
    random_phase(150, 2);
    drain();

    set_sphere(32'h0010_0000, 32'h0020_0000, 32'hFFE0_0000, 32'h0000_0100);
    random_phase(100, 1);
    drain();

    set_sphere($urandom(), $urandom(), $urandom(), $urandom_range(1, 32'h7FFF_FFFF));
    random_phase(150, 0);
    drain();

    set_sphere(0, 0, 0, 32'h0010_0000);
    random_phase(150, 2);
    drain();

    if (sb.errors == 0)
      $display("** ray_sphere_intersect: PASSED **");
    else
      $display("** ray_sphere_intersect: FAILED **");
    $finish;
  end
endmodule
